FILE: hw/rtl/lslw_pkg.sv
// ----------------------------------------------------------------------------
// lslw_pkg
// Shared types, constants and saturation helpers for the lattice whitener.
// ----------------------------------------------------------------------------
`default_nettype none

package lslw_pkg;

  localparam int MAX_ORDER_DEF = 16;

  localparam logic [15:0] FF_RESET     = 16'd65208;
  localparam logic [46:0] INIT_E_RESET = 47'd65536;
  localparam logic [4:0]  ORDER_RESET  = 5'd16;

  localparam logic [1:0] REG_FF     = 2'd0;
  localparam logic [1:0] REG_INIT_E = 2'd1;
  localparam logic [1:0] REG_ORDER  = 2'd2;

  localparam int DIV_STEPS = 40;

  typedef enum logic [1:0] {
    SH_0,
    SH_14,
    SH_16,
    SH_30
  } sh_t;

  typedef struct packed {
    logic               start;
    logic signed [48:0] a;
    logic signed [48:0] b;
    sh_t                sh;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic [47:0]        den;
  } div_req_t;

  function automatic logic [47:0] eclamp(input logic signed [63:0] v);
    logic [47:0] r;
    if (v < 64'sd1) begin
      r = 48'd1;
    end else if (v > 64'sh0000_FFFF_FFFF_FFFF) begin
      r = 48'hFFFF_FFFF_FFFF;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] errclamp(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qclamp(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lsl_lattice_whitener.sv
// ----------------------------------------------------------------------------
// lsl_lattice_whitener
// Adaptive least-squares lattice whitening filter with a shared multiplier
// and divider under a per-stage micro-op sequencer.
// ----------------------------------------------------------------------------
// channel   direction  data
// apb       slave      forgetting_factor @0x00, initial_energy @0x08,
//                      order_in_use @0x10 (64-bit data)
// s_axis    in         tdata[15:0] sample
// m_axis    out        tdata[23:0] whitened
//
// Each active stage runs eleven multiplies and three multiply-divides (a
// divide ends early when the quotient saturates), plus load and advance;
// each sample also needs accept and output. All of it runs on the
// single multiplier and the bit-serial divider.
// Reset restores register defaults, sets stage energies to initial energy and clears the other stage state.
// s_axis_tready is high only while idle; a finished result waits in the output
// register and holds the sequencer only if it is still untaken at completion.
// ----------------------------------------------------------------------------
`default_nettype none

module lsl_lattice_whitener #(
  parameter int MAX_ORDER = lslw_pkg::MAX_ORDER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata    // [23:0] whitened
);

  localparam int NST = MAX_ORDER + 1;
  localparam int KW  = $clog2(NST);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_MWAIT,
    ST_DWAIT,
    ST_NEXT,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_FFE_F,
    OP_SQ_F,
    OP_EN_F,
    OP_FFE_B,
    OP_SQ_B,
    OP_EN_B,
    OP_EF,
    OP_EB,
    OP_PF,
    OP_MF,
    OP_PB,
    OP_MB,
    OP_GG,
    OP_MG
  } op_t;

  logic [15:0] ff;
  logic [46:0] init_e;
  logic [4:0]  order;

  logic signed [23:0] peb [NST];
  logic [47:0]        fe  [NST];
  logic [47:0]        be  [NST];
  logic signed [31:0] fr  [NST];
  logic signed [31:0] br  [NST];

  state_t state;
  op_t    op;
  logic [KW-1:0] k;
  logic [KW-1:0] n_r;
  logic [KW-1:0] t;
  logic [KW-1:0] n_eff;

  logic signed [23:0] ef, ebp, efk, ebk, pend;
  logic signed [31:0] g, kf, kb;
  logic [47:0]        epf_old, epb_old, epf, epb, acc;
  logic signed [63:0] tmp, sqb;

  logic               cfg_wr;
  logic [47:0]        e_init_val;
  logic [47:0]        e_rst_val;

  lslw_pkg::mul_req_t mul_req;
  lslw_pkg::div_req_t div_req;
  logic               mul_done, div_done;
  logic signed [63:0] mul_res;
  logic signed [41:0] div_q;
  logic               div_op;

  lslw_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .res  (mul_res)
  );

  lslw_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .q    (div_q)
  );

  assign pready        = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign t             = k - KW'(1);
  assign e_init_val    = (pwdata[46:0] == 47'd0) ? 48'd1 : {1'b0, pwdata[46:0]};
  assign e_rst_val     = {1'b0, lslw_pkg::INIT_E_RESET};

  always_comb begin
    if (order == 5'd0) begin
      n_eff = KW'(1);
    end else if (32'(order) > MAX_ORDER) begin
      n_eff = KW'(MAX_ORDER);
    end else begin
      n_eff = KW'(order);
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      lslw_pkg::REG_FF:     prdata = {48'd0, ff};
      lslw_pkg::REG_INIT_E: prdata = {17'd0, init_e};
      lslw_pkg::REG_ORDER:  prdata = {59'd0, order};
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    mul_req.start = (state == ST_MUL);
    unique case (op)
      OP_FFE_F: begin
        mul_req.a = {33'd0, ff};
        mul_req.b = {1'b0, epf_old};
        mul_req.sh = lslw_pkg::SH_16;
      end
      OP_SQ_F: begin
        mul_req.a = {{25{ef[23]}}, ef};
        mul_req.b = {{25{ef[23]}}, ef};
        mul_req.sh = lslw_pkg::SH_0;
      end
      OP_EN_F: begin
        mul_req.a = {{17{g[31]}}, g};
        mul_req.b = tmp[48:0];
        mul_req.sh = lslw_pkg::SH_14;
      end
      OP_FFE_B: begin
        mul_req.a = {33'd0, ff};
        mul_req.b = {1'b0, epb_old};
        mul_req.sh = lslw_pkg::SH_16;
      end
      OP_SQ_B: begin
        mul_req.a = {{25{ebp[23]}}, ebp};
        mul_req.b = {{25{ebp[23]}}, ebp};
        mul_req.sh = lslw_pkg::SH_0;
      end
      OP_EN_B: begin
        mul_req.a = {{17{g[31]}}, g};
        mul_req.b = sqb[48:0];
        mul_req.sh = lslw_pkg::SH_14;
      end
      OP_EF: begin
        mul_req.a = {{17{kf[31]}}, kf};
        mul_req.b = {{25{ebp[23]}}, ebp};
        mul_req.sh = lslw_pkg::SH_30;
      end
      OP_EB: begin
        mul_req.a = {{17{kb[31]}}, kb};
        mul_req.b = {{25{ef[23]}}, ef};
        mul_req.sh = lslw_pkg::SH_30;
      end
      OP_PF: begin
        mul_req.a = {{25{ebp[23]}}, ebp};
        mul_req.b = {{25{efk[23]}}, efk};
        mul_req.sh = lslw_pkg::SH_0;
      end
      OP_PB: begin
        mul_req.a = {{25{ef[23]}}, ef};
        mul_req.b = {{25{ebk[23]}}, ebk};
        mul_req.sh = lslw_pkg::SH_0;
      end
      OP_GG: begin
        mul_req.a = {{17{g[31]}}, g};
        mul_req.b = {{17{g[31]}}, g};
        mul_req.sh = lslw_pkg::SH_30;
      end
      OP_MG: begin
        mul_req.a = tmp[48:0];
        mul_req.b = sqb[48:0];
        mul_req.sh = lslw_pkg::SH_14;
      end
      default: begin
        mul_req.a = {{17{g[31]}}, g};
        mul_req.b = tmp[48:0];
        mul_req.sh = lslw_pkg::SH_14;
      end
    endcase
  end

  always_comb begin
    div_op        = (op == OP_MF) || (op == OP_MB) || (op == OP_MG);
    div_req.start = (state == ST_MWAIT) && mul_done && div_op;
    div_req.num   = mul_res;
    div_req.den   = (op == OP_MB) ? epf : epb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      op            <= OP_FFE_F;
      m_axis_tvalid <= 1'b0;
      ff            <= lslw_pkg::FF_RESET;
      init_e        <= lslw_pkg::INIT_E_RESET;
      order         <= lslw_pkg::ORDER_RESET;
      for (int i = 0; i < NST; i++) begin
        peb[i] <= '0;
        fe[i]  <= e_rst_val;
        be[i]  <= e_rst_val;
        fr[i]  <= '0;
        br[i]  <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ef    <= $signed({{8{s_axis_tdata[15]}}, s_axis_tdata});
            pend  <= $signed({{8{s_axis_tdata[15]}}, s_axis_tdata});
            g     <= 32'sh4000_0000;
            k     <= KW'(1);
            n_r   <= n_eff;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ebp     <= peb[t];
          epf_old <= fe[t];
          epb_old <= be[t];
          kf      <= fr[k];
          kb      <= br[k];
          peb[t]  <= pend;
          op      <= OP_FFE_F;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            unique case (op)
              OP_FFE_F, OP_FFE_B: acc <= mul_res[47:0];
              OP_SQ_F, OP_PF, OP_PB, OP_GG: tmp <= mul_res;
              OP_SQ_B: sqb <= mul_res;
              OP_EN_F: begin
                epf   <= lslw_pkg::eclamp($signed({16'd0, acc}) + mul_res);
                fe[t] <= lslw_pkg::eclamp($signed({16'd0, acc}) + mul_res);
              end
              OP_EN_B: begin
                epb   <= lslw_pkg::eclamp($signed({16'd0, acc}) + mul_res);
                be[t] <= lslw_pkg::eclamp($signed({16'd0, acc}) + mul_res);
              end
              OP_EF: efk <= lslw_pkg::errclamp($signed({{40{ef[23]}}, ef}) + mul_res);
              OP_EB: ebk <= lslw_pkg::errclamp($signed({{40{ebp[23]}}, ebp}) + mul_res);
              default: ;
            endcase
            if (div_op) begin
              state <= ST_DWAIT;
            end else begin
              op    <= op_t'(op + 4'd1);
              state <= ST_MUL;
            end
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            unique case (op)
              OP_MF: begin
                fr[k] <= lslw_pkg::qclamp($signed({{32{kf[31]}}, kf})
                                          - $signed({{22{div_q[41]}}, div_q}));
                op    <= op_t'(op + 4'd1);
                state <= ST_MUL;
              end
              OP_MB: begin
                br[k] <= lslw_pkg::qclamp($signed({{32{kb[31]}}, kb})
                                          - $signed({{22{div_q[41]}}, div_q}));
                op    <= op_t'(op + 4'd1);
                state <= ST_MUL;
              end
              default: begin
                g     <= lslw_pkg::qclamp($signed({{32{g[31]}}, g})
                                          - $signed({{22{div_q[41]}}, div_q}));
                state <= ST_NEXT;
              end
            endcase
          end
        end
        ST_NEXT: begin
          ef   <= efk;
          pend <= ebk;
          if (k == n_r) begin
            peb[k] <= ebk;
            state  <= ST_FINISH;
          end else begin
            k     <= k + KW'(1);
            state <= ST_LOAD;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= ef;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_wr) begin
        unique case (paddr[4:3])
          lslw_pkg::REG_FF:    ff <= pwdata[15:0];
          lslw_pkg::REG_ORDER: order <= pwdata[4:0];
          lslw_pkg::REG_INIT_E: begin
            init_e <= pwdata[46:0];
            for (int i = 0; i < NST; i++) begin
              peb[i] <= '0;
              fe[i]  <= e_init_val;
              be[i]  <= e_init_val;
              fr[i]  <= '0;
              br[i]  <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lslw_mul.sv
// ----------------------------------------------------------------------------
// lslw_mul
// Sequential signed multiplier: accumulates 49x17 partial products over the 17-bit chunks of b,
// then shifts right, saturates the magnitude at 2^62 and restores the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lslw_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lslw_pkg::mul_req_t req,
  output logic                    done,
  output logic signed [63:0]      res
);

  logic [48:0]   mag_a;
  logic [50:0]   mag_b;
  logic          neg;
  lslw_pkg::sh_t sh;
  logic [96:0]   acc;
  logic [1:0]    phase;
  logic          busy;

  logic [16:0]        chunk;
  logic [65:0]        pp;
  logic [96:0]        pp_sh;
  logic [96:0]        shd;
  logic               sat;
  logic [62:0]        mag63;
  logic signed [63:0] res_next;

  always_comb begin
    unique case (phase)
      2'd0: chunk = mag_b[16:0];
      2'd1: chunk = mag_b[33:17];
      2'd2: chunk = mag_b[50:34];
      default: chunk = '0;
    endcase
    pp = mag_a * chunk;
    unique case (phase)
      2'd0: pp_sh = 97'(pp);
      2'd1: pp_sh = 97'(pp) << 17;
      2'd2: pp_sh = 97'(pp) << 34;
      default: pp_sh = '0;
    endcase
  end

  always_comb begin
    unique case (sh)
      lslw_pkg::SH_0:  shd = acc;
      lslw_pkg::SH_14: shd = acc >> 14;
      lslw_pkg::SH_16: shd = acc >> 16;
      lslw_pkg::SH_30: shd = acc >> 30;
      default:         shd = acc;
    endcase
    sat      = (|shd[96:63]) | (shd[62] & (|shd[61:0]));
    mag63    = sat ? {1'b1, 62'd0} : shd[62:0];
    res_next = neg ? -$signed({1'b0, mag63}) : $signed({1'b0, mag63});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        mag_a <= req.a[48] ? 49'(-req.a) : 49'(req.a);
        mag_b <= {2'b00, (req.b[48] ? 49'(-req.b) : 49'(req.b))};
        neg   <= req.a[48] ^ req.b[48];
        sh    <= req.sh;
        acc   <= '0;
        phase <= 2'd0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (phase == 2'd3) begin
          res  <= res_next;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          acc   <= acc + pp_sh;
          phase <= phase + 2'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lslw_div.sv
// ----------------------------------------------------------------------------
// lslw_div
// Restoring divider for (num * 2^30) / den, one quotient bit per cycle,
// truncated toward zero and saturated at magnitude 2^40.
// ----------------------------------------------------------------------------
`default_nettype none

module lslw_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lslw_pkg::div_req_t req,
  output logic                    done,
  output logic signed [41:0]      q
);

  logic [47:0] den_r;
  logic [47:0] rem;
  logic [39:0] nb;
  logic [39:0] quo;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;

  logic [63:0] mag;
  logic [53:0] hi;
  logic [47:0] den_eff;
  logic [48:0] trial;
  logic        take;
  logic [39:0] quo_next;

  always_comb begin
    mag      = req.num[63] ? 64'(-req.num) : 64'(req.num);
    hi       = mag[63:10];
    den_eff  = (req.den == 48'd0) ? 48'd1 : req.den;
    trial    = {rem, nb[39]};
    take     = trial >= {1'b0, den_r};
    quo_next = {quo[38:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg   <= req.num[63];
        den_r <= den_eff;
        if (hi >= {6'd0, den_eff}) begin
          q    <= req.num[63] ? -$signed({2'b01, 40'd0}) : $signed({2'b01, 40'd0});
          done <= 1'b1;
        end else begin
          rem  <= hi[47:0];
          nb   <= {mag[9:0], 30'd0};
          quo  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= take ? 48'(trial - {1'b0, den_r}) : trial[47:0];
        nb  <= {nb[38:0], 1'b0};
        quo <= quo_next;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(lslw_pkg::DIV_STEPS - 1)) begin
          q    <= neg ? -$signed({2'b00, quo_next}) : $signed({2'b00, quo_next});
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire
